// ===== hdl/imufhd_pkg.sv =====
// Shared constants and types for the IMU frame heading decoder.
package imufhd_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACC   = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    // position of the checksum byte, the last of an 11-byte frame
    localparam logic [3:0] LAST_POS = 4'd10;

    localparam logic [1:0] KIND_ACC   = 2'd0;
    localparam logic [1:0] KIND_RATE  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] vz;
        logic        gps_fixed;
        logic [15:0] gps_heading;
    } frame_rec_t;

    localparam int REC_W = $bits(frame_rec_t);

    typedef struct packed {
        logic       push;
        frame_rec_t rec;
    } front_push_t;

endpackage

// ===== hdl/imu_frame_heading_decoder.sv =====
// Top level of the IMU frame heading decoder: framer, queue and heading stage.
//
// Takes one serial byte per transfer (with the GPS heading and fix flag that go with it)
// and frames 11-byte IMU packets. A 0x55 byte always restarts a frame; after the first
// one the block stays in sync, so each following run of ten bytes is a frame. Types
// 0x51/0x52/0x53 give one result transfer: kind on m_tuser, the three signed
// little-endian axis words, and for angle frames a clockwise heading in 1/65536 turn
// corrected by a learned GPS offset (learned, and no heading flagged, while the fix flag
// is set on the checksum byte). Other types give nothing; the checksum is not checked.
// Rate: one byte per cycle while the queue is not full. A result is queued on the
// checksum byte's transfer, then moves to the output register. s_tready falls only when
// the queue (QUEUE_DEPTH entries) is full, which takes a result held up by m_tready.
module imu_frame_heading_decoder
    import imufhd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] rx_byte, [8] gps_fixed, [24:9] gps_heading, [31:25] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] value_x, [31:16] value_y, [47:32] value_z, [63:48] heading,
    // [64] heading_valid, [71:65] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // [1:0] frame_kind
    output logic [OUT_USER_W-1:0] m_tuser
);

    front_push_t      push_s;
    logic             queue_full;
    logic             q_valid;
    logic             q_pop;
    logic [REC_W-1:0] q_data;
    frame_rec_t       q_rec;

    // framer: sync tracking and byte collection
    imufhd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push_out   (push_s)
    );

    // decouples framing from the output handshake
    imufhd_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_s.push),
        .push_data (push_s.rec),
        .full      (queue_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    assign q_rec = frame_rec_t'(q_data);

    // heading correction and result register
    imufhd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_rec    (q_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // the framer must never push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push_s.push && queue_full))
        else $error("frame pushed into full queue");

    // heading is zero whenever it is not flagged valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[64]) |-> (m_tdata[63:48] == 16'd0))
        else $error("heading non-zero without heading_valid");

    // only angle frames carry a valid heading
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[64]) |-> (m_tuser == KIND_ANGLE))
        else $error("heading_valid on non-angle frame");

    // a popped record shows up on the output in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> m_tvalid)
        else $error("popped frame not presented");
`endif

endmodule

// ===== hdl/imufhd_front.sv =====
// Byte framer: tracks sync and position, collects frame bytes, queues decoded frames.
module imufhd_front
    import imufhd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 queue_full,
    output front_push_t          push_out
);

    logic [3:0]  index_reg, index_next;
    logic        synced_reg, synced_next;
    logic [7:0]  bytes_reg [1:7];
    logic [3:0]  pos;
    logic        wr_en;
    logic        accept;
    logic [7:0]  rx_byte;
    logic        gps_fixed;
    logic [15:0] gps_heading;

    assign rx_byte     = s_tdata[7:0];
    assign gps_fixed   = s_tdata[8];
    assign gps_heading = s_tdata[24:9];

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && !queue_full;
    assign pos      = (index_reg >= LAST_POS) ? 4'd1 : index_reg + 4'd1;

    always_comb
    begin
        index_next  = index_reg;
        synced_next = synced_reg;
        wr_en       = 1'b0;
        push_out    = '0;
        push_out.rec.vx          = {bytes_reg[3], bytes_reg[2]};
        push_out.rec.vy          = {bytes_reg[5], bytes_reg[4]};
        push_out.rec.vz          = {bytes_reg[7], bytes_reg[6]};
        push_out.rec.gps_fixed   = gps_fixed;
        push_out.rec.gps_heading = gps_heading;
        case (bytes_reg[1])
            TYPE_ACC:   push_out.rec.kind = KIND_ACC;
            TYPE_RATE:  push_out.rec.kind = KIND_RATE;
            default:    push_out.rec.kind = KIND_ANGLE;
        endcase
        if (accept)
        begin
            if (rx_byte == HDR_BYTE)
            begin
                index_next  = 4'd0;
                synced_next = 1'b1;
            end
            else if (synced_reg)
            begin
                wr_en = 1'b1;
                if (pos == LAST_POS)
                begin
                    index_next    = 4'd0;
                    push_out.push = (bytes_reg[1] == TYPE_ACC) ||
                                    (bytes_reg[1] == TYPE_RATE) ||
                                    (bytes_reg[1] == TYPE_ANGLE);
                end
                else
                begin
                    index_next = pos;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg  <= 4'd0;
            synced_reg <= 1'b0;
        end
        else
        begin
            index_reg  <= index_next;
            synced_reg <= synced_next;
        end
    end

    // bytes 1..7 are always rewritten before a frame completes; no reset needed
    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= 7; k++)
        begin
            if (wr_en && (pos == 4'(k)))
            begin
                bytes_reg[k] <= rx_byte;
            end
        end
    end

endmodule

// ===== hdl/imufhd_fifo.sv =====
// Small register queue between framer and heading stage.
module imufhd_fifo
    import imufhd_pkg::*;
#(
    parameter int WIDTH = REC_W,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/imufhd_back.sv =====
// Heading stage: offset learning / correction and the output register.
module imufhd_back
    import imufhd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  frame_rec_t            q_rec,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    // only the low 16 bits of the offset reach the wrapped heading
    logic [15:0] offset_reg, offset_next;
    logic        out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] data_reg, data_next;
    logic [OUT_USER_W-1:0] user_reg, user_next;
    logic [15:0] head_turn;    // low 16 bits of 65536 - yaw
    logic [15:0] head;
    logic        head_valid;

    assign q_pop     = q_valid && (!out_valid_reg || m_tready);
    assign head_turn = 16'd0 - q_rec.vz;

    always_comb
    begin
        offset_next = offset_reg;
        head        = 16'd0;
        head_valid  = 1'b0;
        if (q_rec.kind == KIND_ANGLE)
        begin
            if (q_rec.gps_fixed)
            begin
                offset_next = q_rec.gps_heading - head_turn;
            end
            else
            begin
                head       = head_turn + offset_reg;
                head_valid = 1'b1;
            end
        end
        if (!q_pop)
        begin
            offset_next = offset_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        user_next      = user_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (q_pop)
        begin
            out_valid_next = 1'b1;
            data_next      = {7'd0, head_valid, head, q_rec.vz, q_rec.vy, q_rec.vx};
            user_next      = q_rec.kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        user_reg <= user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

// ===== tb/imufhd_tb_pkg.sv =====
// Result type and scoreboard for the IMU frame heading decoder testbench.
`timescale 1ns / 1ps

package imufhd_tb_pkg;

    import imufhd_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] vz;
        logic [15:0] heading;
        logic        heading_valid;
    } imu_result_t;

    class heading_scoreboard;

        logic [7:0]  frame_buf [11];
        logic [3:0]  last_pos;
        bit          in_sync;
        logic [17:0] gps_offset;     // two's complement, 18 bits
        imu_result_t pending [$];
        int          errors;
        int          results_checked;
        int          kind_count [3];
        int          headings_corrected;
        int          offsets_learned;

        function new();
            foreach (frame_buf[i])
                frame_buf[i] = 8'h00;
            last_pos   = 4'd0;
            in_sync    = 1'b0;
            gps_offset = 18'd0;
            errors     = 0;
            results_checked = 0;
            foreach (kind_count[i])
                kind_count[i] = 0;
            headings_corrected = 0;
            offsets_learned    = 0;
        endfunction

        // one accepted byte transfer; queues the result it completes, if any
        function void note_byte(logic [7:0] rx, logic fixed, logic [15:0] gps);
            imu_result_t r;
            logic [16:0] turn;
            bit          decoded;
            if (rx == HDR_BYTE)
            begin
                foreach (frame_buf[i])
                    frame_buf[i] = 8'h00;
                frame_buf[0] = HDR_BYTE;
                last_pos     = 4'd0;
                in_sync      = 1'b1;
                return;
            end
            if (!in_sync)
                return;
            if (last_pos >= LAST_POS)
                last_pos = 4'd0;
            last_pos = last_pos + 4'd1;
            frame_buf[last_pos] = rx;
            if (last_pos != LAST_POS)
                return;

            r         = '0;
            r.vx      = {frame_buf[3], frame_buf[2]};
            r.vy      = {frame_buf[5], frame_buf[4]};
            r.vz      = {frame_buf[7], frame_buf[6]};
            decoded   = 1'b1;
            case (frame_buf[1])
                TYPE_ACC:  r.kind = KIND_ACC;
                TYPE_RATE: r.kind = KIND_RATE;
                TYPE_ANGLE:
                begin
                    r.kind = KIND_ANGLE;
                    // clockwise heading, 1..65536
                    turn = 17'h10000 - {1'b0, r.vz};
                    if (fixed)
                        gps_offset = {2'b00, gps} - {1'b0, turn};
                    else
                    begin
                        r.heading       = turn[15:0] + gps_offset[15:0];
                        r.heading_valid = 1'b1;
                    end
                end
                default: decoded = 1'b0;
            endcase
            if (decoded)
                pending.push_back(r);
            foreach (frame_buf[i])
                frame_buf[i] = 8'h00;
            last_pos = 4'd0;
        endfunction

        function void check_result(imu_result_t got);
            imu_result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result kind %0d x %h y %h z %h hdg %h/%b",
                             $realtime, got.kind, got.vx, got.vy, got.vz,
                             got.heading, got.heading_valid);
                return;
            end
            want = pending.pop_front();
            results_checked++;
            if (got.kind !== want.kind || got.vx !== want.vx || got.vy !== want.vy ||
                got.vz !== want.vz || got.heading !== want.heading ||
                got.heading_valid !== want.heading_valid)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t: result %0d mismatch", $realtime, results_checked);
                    $display("  expected kind %0d x %h y %h z %h hdg %h/%b",
                             want.kind, want.vx, want.vy, want.vz,
                             want.heading, want.heading_valid);
                    $display("  actual   kind %0d x %h y %h z %h hdg %h/%b",
                             got.kind, got.vx, got.vy, got.vz,
                             got.heading, got.heading_valid);
                end
            end
            if (want.kind <= KIND_ANGLE)
                kind_count[want.kind]++;
            if (want.heading_valid)
                headings_corrected++;
            else if (want.kind == KIND_ANGLE)
                offsets_learned++;
        endfunction

    endclass

endpackage

// ===== tb/imu_frame_heading_decoder_tb.sv =====
// Self-checking testbench for the IMU frame heading decoder stream block.
`timescale 1ns / 1ps

module imu_frame_heading_decoder_tb;

    import imufhd_pkg::*;
    import imufhd_tb_pkg::*;

    localparam int ITEM_TARGET  = 1550;
    localparam int QUIET_TAIL   = 300;   // final stretch with no idling on either side
    localparam int HOLD_CYCLES  = 600;   // long receiver hold-off to back the block up
    localparam int SEGMENT_LEN  = 150;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    heading_scoreboard sb;

    // idle intensity per side: 0 none, 1 light, 2 heavy
    int idle_level  = 0;
    int stall_level = 0;
    bit hold_request = 1'b0;
    int bytes_sent = 0;

    imu_frame_heading_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    // Drives one byte transfer, with an optional gap in front; returns on the
    // falling edge after the transfer so the next call can keep tvalid high.
    task automatic push_byte(input logic [7:0] rx, input logic fixed, input logic [15:0] gps);
        if (idle_level != 0 && $urandom_range(0, idle_level == 1 ? 9 : 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, gps, fixed, rx};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(rx, fixed, gps);
        bytes_sent++;
        @(negedge clk);
    endtask

    // payload byte; a stray header in the body is kept now and then so that
    // mid-frame resync gets exercised
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = $urandom_range(0, 255);
        if (b == HDR_BYTE && $urandom_range(0, 7) != 0)
            b = ~b;
        return b;
    endfunction

    // One frame: optional header then body_len of the ten bytes after it.
    // A short body_len leaves a broken frame for the next header to discard.
    task automatic send_frame(input bit with_header, input int body_len);
        logic [7:0]  body [10];
        logic [15:0] w;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 30)
            body[0] = TYPE_ACC;
        else if (r < 60)
            body[0] = TYPE_RATE;
        else if (r < 90)
            body[0] = TYPE_ANGLE;
        else
            body[0] = body_byte();
        for (int i = 1; i <= 5; i += 2)
        begin
            case ($urandom_range(0, 15))
                0:       w = 16'h0000;
                1:       w = 16'h7FFF;
                2:       w = 16'h8000;
                3:       w = 16'hFFFF;
                default: w = {body_byte(), body_byte()};
            endcase
            body[i]     = w[7:0];
            body[i + 1] = w[15:8];
        end
        for (int i = 7; i < 10; i++)
            body[i] = body_byte();
        if (with_header)
            push_byte(HDR_BYTE, 1'($urandom_range(0, 1)), 16'($urandom));
        for (int i = 0; i < body_len; i++)
        begin
            if (i == 9)
            begin
                // checksum byte: fix flag and GPS heading here decide the heading path
                case ($urandom_range(0, 7))
                    0:       w = 16'h0000;
                    1:       w = 16'hFFFF;
                    default: w = 16'($urandom);
                endcase
                push_byte(body[i], $urandom_range(0, 3) == 0, w);
            end
            else
                push_byte(body[i], 1'($urandom_range(0, 1)), 16'($urandom));
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end
            else if (stall_level != 0 && $urandom_range(0, stall_level == 1 ? 9 : 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Output monitor: every result transfer goes to the scoreboard.
    always @(posedge clk)
    begin
        imu_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind          = m_tuser[1:0];
            got.vx            = m_tdata[15:0];
            got.vy            = m_tdata[31:16];
            got.vz            = m_tdata[47:32];
            got.heading       = m_tdata[63:48];
            got.heading_valid = m_tdata[64];
            sb.check_result(got);
        end
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("imu_frame_heading_decoder verification failed");
        $finish;
    end

    initial
    begin
        // Directed opening: a byte before sync (ignored), a header, an angle frame
        // at zero yaw with offset zero (full turn wraps to 0), a headerless angle
        // frame that learns the offset from an extreme GPS heading, then a partial
        // frame cut short by a header.
        logic [7:0] opening [25] = '{
            8'hAA, HDR_BYTE,
            TYPE_ANGLE, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF,
            TYPE_ANGLE, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h00,
            TYPE_ACC, 8'h12, HDR_BYTE
        };
        int next_switch;
        int pick;
        int drain;
        bit hold_done;

        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening[i])
            push_byte(opening[i], i == 21, 16'hFFFF);

        // Random part: mostly well-formed frames, with headerless runs, broken
        // frames and raw noise mixed in; idle intensity changes per segment.
        next_switch = bytes_sent;
        hold_done   = 1'b0;
        while (bytes_sent < ITEM_TARGET)
        begin
            if (bytes_sent >= ITEM_TARGET - QUIET_TAIL)
            begin
                idle_level  = 0;
                stall_level = 0;
            end
            else if (bytes_sent >= next_switch)
            begin
                idle_level  = $urandom_range(0, 2);
                stall_level = $urandom_range(0, 2);
                next_switch += SEGMENT_LEN;
            end
            if (!hold_done && bytes_sent >= 500)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_frame(1'b1, 10);
            else if (pick < 85)
                send_frame(1'b0, 10);
            else if (pick < 93)
                send_frame(1'b1, $urandom_range(1, 9));
            else
                repeat ($urandom_range(1, 5))
                    push_byte(8'($urandom), 1'($urandom_range(0, 1)), 16'($urandom));
        end
        s_tvalid <= 1'b0;

        drain = 0;
        while (sb.pending.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (16) @(posedge clk);

        if (sb.pending.size() != 0)
        begin
            $display("%0d expected results never arrived", sb.pending.size());
            sb.errors += sb.pending.size();
        end

        $display("Sent %0d bytes; checked %0d results (%0d accel, %0d rate, %0d angle).",
                 bytes_sent, sb.results_checked, sb.kind_count[KIND_ACC],
                 sb.kind_count[KIND_RATE], sb.kind_count[KIND_ANGLE]);
        $display("Angle frames: %0d corrected headings, %0d offset updates; %0d errors.",
                 sb.headings_corrected, sb.offsets_learned, sb.errors);
        if (sb.errors == 0)
            $display("imu_frame_heading_decoder verification clean");
        else
            $display("imu_frame_heading_decoder verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/imufhd_pkg.sv
hdl/imufhd_front.sv
hdl/imufhd_fifo.sv
hdl/imufhd_back.sv
hdl/imu_frame_heading_decoder.sv
tb/imufhd_tb_pkg.sv
tb/imu_frame_heading_decoder_tb.sv
